### rtl/core/wpwr_pkg.sv
package wpwr_pkg;

   // Operation codes carried on the request tuser
   localparam int unsigned OP_W = 2;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_WRITE     = 2'd0;
   localparam op_type OP_PICK_NEW  = 2'd1;
   localparam op_type OP_PICK_CONT = 2'd2;
   localparam op_type OP_NONE      = 2'd3;

   // Fixed field widths
   localparam int unsigned WEIGHT_W  = 32;
   localparam int unsigned RND_W     = 64;
   localparam int unsigned BIT_W     = $clog2(RND_W);
   localparam int unsigned IDX_OUT_W = 6;
   localparam int unsigned CSR_W     = 7;

   // Stream payload widths (whole bytes)
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 8;

   typedef logic [WEIGHT_W-1:0] weight_type;

endpackage

### rtl/core/wpwr_alu.sv
module wpwr_alu #(
   parameter int unsigned W = 39
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         subtract,
   output logic [W-1:0] result,
   output logic         carry
);

   logic [W:0] full;
   logic [W-1:0] b_eff;

   // Subtract as a + ~b + 1; carry set means a >= b
   always_comb begin
      b_eff  = subtract ? ~b : b;
      full   = {1'b0, a} + {1'b0, b_eff} + (W+1)'(subtract);
      result = full[W-1:0];
      carry  = full[W];
   end

endmodule

### rtl/core/wpwr_wmem.sv
module wpwr_wmem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  wpwr_pkg::weight_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output wpwr_pkg::weight_type rd_data
);

   import wpwr_pkg::*;

   weight_type weight_mem_ff [DEPTH];
   weight_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= weight_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/weighted_pick_without_replacement.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: operation; tdata: index, weight, random
// rsp      out  rsp_tvalid/rsp_tready  tuser: chosen_valid; tdata: chosen_index
// csr      in   csr_wr_en              csr_wr_data: entry_count
//
// A write, a no-op or a pick on an empty table goes through the response state
// to the output register as an invalid result. A pick runs a sum pass over the
// candidate weights, a restoring modulo over the 64 random bits and a subtracting
// walk; a refill of the candidates adds one more sum pass. The single weight
// memory read port and the one shared adder/subtractor serialise these passes.
// Reset is synchronous and clears the sequencer, candidates, count and output.
// A waiting result does not block the next item; the sequencer holds only when
// a new result is ready while the previous one is still not taken.
module weighted_pick_without_replacement #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, low bit up: entry_index[5:0], weight_value[37:6],
   // random_value[101:38], zero fill[103:102]
   input  logic [wpwr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: operation[1:0]
   input  logic [wpwr_pkg::OP_W-1:0]         req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata, low bit up: chosen_index[5:0], zero fill[7:6]
   output logic [wpwr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: chosen_valid[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [wpwr_pkg::CSR_W-1:0]        csr_wr_data
);

   import wpwr_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned SUM_W = WEIGHT_W + CNT_W;
   localparam int unsigned ALU_W = SUM_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [MAX_ENTRIES-1:0] mask_ff, mask_in;
   logic [CSR_W-1:0]       count_ff;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [SUM_W-1:0]       rem_ff, rem_in;
   logic [RND_W-1:0]       rnd_ff, rnd_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   first_seen_ff, first_seen_in;
   logic [IDX_W-1:0]       first_idx_ff, first_idx_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   logic                   res_valid_ff, res_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   logic [CNT_W-1:0]       used_n;
   logic [MAX_ENTRIES-1:0] full_mask;
   op_type                 req_op;
   logic [IDX_OUT_W-1:0]   req_eidx;
   weight_type             req_weight;
   logic [RND_W-1:0]       req_rnd;
   logic                   accept;
   logic                   issue;
   logic [IDX_W-1:0]       rd_addr;
   weight_type             rd_data;
   logic                   wr_en;
   weight_type             wr_data;
   logic [ALU_W-1:0]       alu_a, alu_b, alu_result, w_ext;
   logic                   alu_sub, alu_carry;
   logic                   pick_done;
   logic [IDX_W-1:0]       pick_idx;

   // Unpack request fields
   assign req_op     = req_tuser;
   assign req_eidx   = req_tdata[5:0];
   assign req_weight = req_tdata[37:6];
   assign req_rnd    = req_tdata[101:38];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Entries in use, saturated to the table size; all of them as candidates
   always_comb begin
      if (32'(count_ff) > 32'(MAX_ENTRIES)) begin
         used_n = CNT_W'(MAX_ENTRIES);
      end else begin
         used_n = CNT_W'(count_ff);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         full_mask[i] = (CNT_W'(i) < used_n);
      end
   end

   // Weight writes: floor zero at one, drop indexes past the table
   assign wr_en   = accept && (req_op == OP_WRITE) && (32'(req_eidx) < 32'(MAX_ENTRIES));
   assign wr_data = (req_weight == '0) ? WEIGHT_W'(1) : req_weight;

   // One weight read per cycle while the walk pointer is inside the entries in use
   assign issue   = (idx_ff < used_n);
   assign rd_addr = idx_ff[IDX_W-1:0];
   assign w_ext   = ALU_W'(rd_data);

   wpwr_wmem #(
      .DEPTH (MAX_ENTRIES),
      .AW    (IDX_W)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_eidx)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared adder/subtractor: accumulate in the sum pass, trial-subtract in the
   // modulo, subtract weights from the roll in the walk
   always_comb begin
      case (state_ff)
         ST_MOD: begin
            alu_a   = {rem_ff, rnd_ff[RND_W-1]};
            alu_b   = ALU_W'(acc_ff);
            alu_sub = 1'b1;
         end
         ST_WALK: begin
            alu_a   = ALU_W'(rem_ff);
            alu_b   = w_ext;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = w_ext;
            alu_sub = 1'b0;
         end
      endcase
   end

   wpwr_alu #(
      .W (ALU_W)
   ) u_alu (
      .a        (alu_a),
      .b        (alu_b),
      .subtract (alu_sub),
      .result   (alu_result),
      .carry    (alu_carry)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      rnd_in        = rnd_ff;
      bit_cnt_in    = bit_cnt_ff;
      first_seen_in = first_seen_ff;
      first_idx_in  = first_idx_ff;
      res_idx_in    = res_idx_ff;
      res_valid_in  = res_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_flag_in   = rsp_flag_ff;
      pick_done     = 1'b0;
      pick_idx      = '0;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_valid_in = 1'b0;
               res_idx_in   = '0;
               rnd_in       = req_rnd;
               idx_in       = '0;
               pend_in      = 1'b0;
               acc_in       = '0;
               if ((req_op == OP_PICK_NEW || req_op == OP_PICK_CONT) && used_n != '0) begin
                  if (req_op == OP_PICK_NEW) begin
                     mask_in = full_mask;
                  end
                  state_in = ST_SUM;
               end else begin
                  // writes, no-op code and empty table answer invalid
                  state_in = ST_RESP;
               end
            end
         end

         ST_SUM: begin
            pend_in     = issue && mask_ff[rd_addr];
            pend_idx_in = rd_addr;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               acc_in = alu_result[SUM_W-1:0];
            end
            if (!issue && !pend_ff) begin
               if (acc_ff == '0) begin
                  // no candidates left: refill and sum again
                  mask_in = full_mask;
                  idx_in  = '0;
               end else begin
                  rem_in     = '0;
                  bit_cnt_in = '1;
                  state_in   = ST_MOD;
               end
            end
         end

         ST_MOD: begin
            // restoring remainder, one random bit per cycle from the top
            rnd_in     = rnd_ff << 1;
            bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            if (alu_carry) begin
               rem_in = alu_result[SUM_W-1:0];
            end else begin
               rem_in = alu_a[SUM_W-1:0];
            end
            if (bit_cnt_ff == '0) begin
               idx_in        = '0;
               pend_in       = 1'b0;
               first_seen_in = 1'b0;
               state_in      = ST_WALK;
            end
         end

         ST_WALK: begin
            pend_in     = issue && mask_ff[rd_addr];
            pend_idx_in = rd_addr;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (!first_seen_ff) begin
                  first_seen_in = 1'b1;
                  first_idx_in  = pend_idx_ff;
               end
               if (!alu_carry) begin
                  // roll below this weight: take it
                  pick_done = 1'b1;
                  pick_idx  = pend_idx_ff;
               end else begin
                  rem_in = alu_result[SUM_W-1:0];
               end
            end else if (!issue) begin
               // walk ran off the end: fall back to the lowest candidate
               pick_done = 1'b1;
               pick_idx  = first_idx_ff;
            end
            if (pick_done) begin
               mask_in[pick_idx] = 1'b0;
               res_valid_in      = 1'b1;
               res_idx_in        = pick_idx;
               pend_in           = 1'b0;
               state_in          = ST_RESP;
            end
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = IDX_OUT_W'(res_idx_ff);
               rsp_flag_in  = res_valid_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      rnd_ff        <= rnd_in;
      bit_cnt_ff    <= bit_cnt_in;
      first_seen_ff <= first_seen_in;
      first_idx_ff  <= first_idx_in;
      res_idx_ff    <= res_idx_in;
      res_valid_ff  <= res_valid_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_idx_ff);
   assign rsp_tuser  = rsp_flag_ff;

`ifndef ASSERT_OFF
   // The roll stays below the candidate total through modulo and walk
   a_roll_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_WALK) |-> (rem_ff < acc_ff))
      else $error("roll not below candidate total");

   // A chosen entry leaves the candidate set
   a_pick_removed: assert property (@(posedge clock) disable iff (reset)
      pick_done |=> !mask_ff[$past(pick_idx)])
      else $error("picked entry still a candidate");

   // A valid pick names an entry in use
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_valid_ff) |-> (CNT_W'(res_idx_ff) < used_n))
      else $error("picked entry outside entries in use");
`endif

endmodule
